@@ rtl/ttf_pkg.sv @@
// Shared types and constants for the triangle tangent frame block.
// No dependencies; every other file imports it.
package ttf_pkg;

    localparam int PosW   = 32;
    localparam int NormW  = 16;
    localparam int TanW   = 16;
    localparam int EdgeW  = PosW + 1;
    localparam int QueueDepth = 2;

    // One triangle as handed from the front to the back: raw edges and the three normals.
    typedef struct packed {
        logic [5:0][EdgeW-1:0]      pos_edge;   // e1 x,y,z then e2 x,y,z
        logic [3:0][EdgeW-1:0]      uv_edge;    // s1, t1, s2, t2
        logic [2:0][2:0][NormW-1:0] nrm;        // [vertex][component]
    } tri_t;

endpackage

@@ rtl/ttf_queue.sv @@
// Small register queue between the front and the back.
// Depends on ttf_pkg for the triangle record type.
module ttf_queue import ttf_pkg::*; #(
    parameter int DEPTH = QueueDepth
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tri_t push_data,
    output logic full,
    input  logic pop,
    output tri_t pop_data,
    output logic empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    tri_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign full     = (cnt_reg == CntW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ rtl/ttf_front.sv @@
// Vertex intake: holds the first two vertices of a group and forms the edges on the third.
// Depends on ttf_pkg.
module ttf_front import ttf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    vtx_valid,
    output logic                    vtx_ready,
    input  logic signed [PosW-1:0]  pos_x,
    input  logic signed [PosW-1:0]  pos_y,
    input  logic signed [PosW-1:0]  pos_z,
    input  logic signed [PosW-1:0]  tex_u,
    input  logic signed [PosW-1:0]  tex_v,
    input  logic signed [NormW-1:0] norm_x,
    input  logic signed [NormW-1:0] norm_y,
    input  logic signed [NormW-1:0] norm_z,
    output logic                    q_push,
    output tri_t                    q_data,
    input  logic                    q_full
);

    logic [1:0]            slot_reg;
    logic [1:0]            slot_next;
    logic [PosW-1:0]       hold_pos_reg [2][3];
    logic [PosW-1:0]       hold_uv_reg  [2][2];
    logic [NormW-1:0]      hold_nrm_reg [2][3];
    logic [PosW-1:0]       cur_pos [3];
    logic [PosW-1:0]       cur_uv  [2];
    logic                  xfer;

    assign cur_pos[0] = pos_x;
    assign cur_pos[1] = pos_y;
    assign cur_pos[2] = pos_z;
    assign cur_uv[0]  = tex_u;
    assign cur_uv[1]  = tex_v;

    // Only the third slot closes the group, so only it waits for room in the queue.
    assign vtx_ready = !slot_reg[1] || !q_full;
    assign xfer      = vtx_valid && vtx_ready;
    assign q_push    = xfer && slot_reg[1];
    assign slot_next = slot_reg[1] ? 2'd0 : slot_reg + 2'd1;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q_data.pos_edge[c] = {hold_pos_reg[1][c][PosW-1], hold_pos_reg[1][c]}
                               - {hold_pos_reg[0][c][PosW-1], hold_pos_reg[0][c]};
            q_data.pos_edge[3+c] = {cur_pos[c][PosW-1], cur_pos[c]}
                                 - {hold_pos_reg[0][c][PosW-1], hold_pos_reg[0][c]};
            q_data.nrm[0][c] = hold_nrm_reg[0][c];
            q_data.nrm[1][c] = hold_nrm_reg[1][c];
        end
        for (int c = 0; c < 2; c++)
        begin
            q_data.uv_edge[c] = {hold_uv_reg[1][c][PosW-1], hold_uv_reg[1][c]}
                              - {hold_uv_reg[0][c][PosW-1], hold_uv_reg[0][c]};
            q_data.uv_edge[2+c] = {cur_uv[c][PosW-1], cur_uv[c]}
                                - {hold_uv_reg[0][c][PosW-1], hold_uv_reg[0][c]};
        end
        q_data.nrm[2][0] = norm_x;
        q_data.nrm[2][1] = norm_y;
        q_data.nrm[2][2] = norm_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
        end
        else if (xfer)
        begin
            slot_reg <= slot_next;
            if (!slot_reg[1])
            begin
                hold_pos_reg[slot_reg[0]][0] <= pos_x;
                hold_pos_reg[slot_reg[0]][1] <= pos_y;
                hold_pos_reg[slot_reg[0]][2] <= pos_z;
                hold_uv_reg[slot_reg[0]][0]  <= tex_u;
                hold_uv_reg[slot_reg[0]][1]  <= tex_v;
                hold_nrm_reg[slot_reg[0]][0] <= norm_x;
                hold_nrm_reg[slot_reg[0]][1] <= norm_y;
                hold_nrm_reg[slot_reg[0]][2] <= norm_z;
            end
        end
    end

endmodule

@@ rtl/ttf_back.sv @@
// Tangent sequencer: direction from the edges, then per vertex orthogonalize,
// square root and divide, with an output register. Depends on ttf_pkg.
module ttf_back import ttf_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  tri_t                   q_data,
    output logic                   tan_valid,
    input  logic                   tan_ready,
    output logic signed [TanW-1:0] tan_x,
    output logic signed [TanW-1:0] tan_y,
    output logic signed [TanW-1:0] tan_z,
    output logic                   degenerate,
    output logic                   last_of_triangle
);

    typedef enum logic [3:0] {
        S_IDLE, S_TRI, S_SIGN, S_DSH, S_DOT, S_WC, S_WZ,
        S_WSH, S_SQ, S_SQRT, S_DPREP, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [30:0] pe_reg  [6];
    logic signed [30:0] te_reg  [4];
    logic signed [NormW-1:0] nrm_reg [3][3];
    logic [2:0]  k_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  vtx_reg;
    logic        degtri_reg;
    logic        res_deg_reg;
    logic        det_zero_reg;
    logic        det_neg_reg;
    logic signed [62:0] acc_reg;
    logic signed [62:0] d_reg [3];
    logic signed [40:0] dot_reg;
    logic signed [56:0] w_reg [3];
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [31:0] len_reg;
    logic [31:0] rem_reg [3];
    logic [15:0] nlo_reg [3];
    logic [15:0] q_reg   [3];

    logic                 tan_valid_reg;
    logic signed [TanW-1:0] tan_reg [3];
    logic                 deg_out_reg;
    logic                 last_reg;

    // Shared multipliers
    logic signed [31:0] a1;
    logic signed [31:0] b1;
    logic signed [63:0] p1;
    logic signed [15:0] a2;
    logic signed [40:0] b2;
    logic signed [56:0] p2;

    logic [32:0] pe_or;
    logic [32:0] te_or;
    logic [32:0] edge_mag_pe [6];
    logic [32:0] edge_mag_te [4];
    logic [1:0]  pe_shift;
    logic [1:0]  te_shift;
    logic signed [32:0] pe_sh [6];
    logic signed [32:0] te_sh [4];
    logic [62:0] d_mag [3];
    logic        d_big;
    logic [56:0] w_mag [3];
    logic        w_big;
    logic        w_zero;
    logic signed [23:0] u [3];
    logic signed [62:0] diff;
    logic [63:0] sq_try;
    logic [32:0] rem2 [3];
    logic        ge [3];
    logic [31:0] mag [3];
    logic [45:0] num [3];
    logic        out_load;

    assign p1 = a1 * b1;
    assign p2 = a2 * b2;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            u[c] = d_reg[c][23:0];
    end

    // Edge block shift: the OR of the magnitudes carries the same top bit as their maximum.
    always_comb
    begin
        pe_or = '0;
        te_or = '0;
        for (int i = 0; i < 6; i++)
        begin
            edge_mag_pe[i] = q_data.pos_edge[i][EdgeW-1] ? ~q_data.pos_edge[i]
                                                         : q_data.pos_edge[i];
            pe_or = pe_or | edge_mag_pe[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            edge_mag_te[i] = q_data.uv_edge[i][EdgeW-1] ? ~q_data.uv_edge[i]
                                                        : q_data.uv_edge[i];
            te_or = te_or | edge_mag_te[i];
        end
        pe_shift = pe_or[31] ? 2'd2 : (pe_or[30] ? 2'd1 : 2'd0);
        te_shift = te_or[31] ? 2'd2 : (te_or[30] ? 2'd1 : 2'd0);
        for (int i = 0; i < 6; i++)
            pe_sh[i] = $signed(q_data.pos_edge[i]) >>> pe_shift;
        for (int i = 0; i < 4; i++)
            te_sh[i] = $signed(q_data.uv_edge[i]) >>> te_shift;
    end

    always_comb
    begin
        d_big  = 1'b0;
        w_big  = 1'b0;
        w_zero = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            d_mag[c] = d_reg[c][62] ? ~d_reg[c] : d_reg[c];
            if (d_mag[c][61:23] != '0)
                d_big = 1'b1;
            w_mag[c] = w_reg[c][56] ? ~w_reg[c] : w_reg[c];
            if (w_mag[c][55:31] != '0)
                w_big = 1'b1;
            if (w_reg[c] != '0)
                w_zero = 1'b0;
            mag[c] = w_reg[c][56] ? 32'(-w_reg[c]) : 32'(w_reg[c]);
            num[c] = {mag[c], 14'd0} + 46'(len_reg >> 1);
            rem2[c] = {rem_reg[c], nlo_reg[c][15]};
            ge[c]   = rem2[c] >= {1'b0, len_reg};
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        a1 = '0;
        b1 = '0;
        a2 = '0;
        b2 = '0;
        case (state_reg)
            S_TRI:
            begin
                case (k_reg)
                    3'd0:    begin a1 = 32'(te_reg[3]); b1 = 32'(pe_reg[0]); end
                    3'd1:    begin a1 = 32'(te_reg[1]); b1 = 32'(pe_reg[3]); end
                    3'd2:    begin a1 = 32'(te_reg[3]); b1 = 32'(pe_reg[1]); end
                    3'd3:    begin a1 = 32'(te_reg[1]); b1 = 32'(pe_reg[4]); end
                    3'd4:    begin a1 = 32'(te_reg[3]); b1 = 32'(pe_reg[2]); end
                    3'd5:    begin a1 = 32'(te_reg[1]); b1 = 32'(pe_reg[5]); end
                    3'd6:    begin a1 = 32'(te_reg[0]); b1 = 32'(te_reg[3]); end
                    default: begin a1 = 32'(te_reg[2]); b1 = 32'(te_reg[1]); end
                endcase
            end
            S_DOT:
            begin
                a2 = nrm_reg[vtx_reg][k_reg[1:0]];
                b2 = 41'(u[k_reg[1:0]]);
            end
            S_WC:
            begin
                a2 = nrm_reg[vtx_reg][k_reg[1:0]];
                b2 = dot_reg;
            end
            S_SQ:
            begin
                a1 = w_reg[k_reg[1:0]][31:0];
                b1 = w_reg[k_reg[1:0]][31:0];
            end
            default:
            begin
                a1 = '0;
            end
        endcase
    end

    assign diff     = acc_reg - 63'(p1);
    assign sq_try   = r_reg + bit_reg;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_OUT) && (!tan_valid_reg || tan_ready);

    assign tan_valid        = tan_valid_reg;
    assign tan_x            = tan_reg[0];
    assign tan_y            = tan_reg[1];
    assign tan_z            = tan_reg[2];
    assign degenerate       = deg_out_reg;
    assign last_of_triangle = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tan_valid_reg <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            vtx_reg       <= '0;
            degtri_reg    <= 1'b0;
            res_deg_reg   <= 1'b0;
        end
        else
        begin
            if (tan_valid_reg && tan_ready && !out_load)
                tan_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        for (int i = 0; i < 6; i++)
                            pe_reg[i] <= pe_sh[i][30:0];
                        for (int i = 0; i < 4; i++)
                            te_reg[i] <= te_sh[i][30:0];
                        for (int v = 0; v < 3; v++)
                            for (int c = 0; c < 3; c++)
                                nrm_reg[v][c] <= q_data.nrm[v][c];
                        k_reg      <= '0;
                        vtx_reg    <= '0;
                        degtri_reg <= 1'b0;
                        state_reg  <= S_TRI;
                    end
                end
                S_TRI:
                begin
                    // Even steps load the first product, odd steps subtract the second.
                    if (!k_reg[0])
                        acc_reg <= 63'(p1);
                    else if (k_reg[2:1] == 2'd3)
                    begin
                        det_zero_reg <= (diff == '0);
                        det_neg_reg  <= diff[62];
                    end
                    else
                        d_reg[k_reg[2:1]] <= diff;
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd7)
                        state_reg <= S_SIGN;
                end
                S_SIGN:
                begin
                    if (det_zero_reg)
                    begin
                        degtri_reg  <= 1'b1;
                        res_deg_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        if (det_neg_reg)
                            for (int c = 0; c < 3; c++)
                                d_reg[c] <= -d_reg[c];
                        state_reg <= S_DSH;
                    end
                end
                S_DSH:
                begin
                    if (d_big)
                        for (int c = 0; c < 3; c++)
                            d_reg[c] <= d_reg[c] >>> 1;
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT:
                begin
                    dot_reg <= ((k_reg == 3'd0) ? 41'sd0 : dot_reg) + 41'(p2);
                    k_reg   <= k_reg + 3'd1;
                    if (k_reg == 3'd2)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_WC;
                    end
                end
                S_WC:
                begin
                    w_reg[k_reg[1:0]] <= (57'(u[k_reg[1:0]]) <<< 28) - p2;
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd2)
                        state_reg <= S_WZ;
                end
                S_WZ:
                begin
                    if (w_zero)
                    begin
                        res_deg_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                        state_reg <= S_WSH;
                end
                S_WSH:
                begin
                    if (w_big)
                        for (int c = 0; c < 3; c++)
                            w_reg[c] <= w_reg[c] >>> 1;
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    x_reg <= ((k_reg == 3'd0) ? 64'd0 : x_reg) + 64'(p1);
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd2)
                    begin
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= 5'd31;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (x_reg >= sq_try)
                    begin
                        x_reg <= x_reg - sq_try;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                        state_reg <= S_DPREP;
                end
                S_DPREP:
                begin
                    len_reg <= r_reg[31:0];
                    state_reg <= S_DIV;
                    cnt_reg <= 5'd16;
                end
                S_DIV:
                begin
                    // First pass loads the numerator; the quotient is known to fit 16 bits.
                    for (int c = 0; c < 3; c++)
                    begin
                        if (cnt_reg == 5'd16)
                        begin
                            rem_reg[c] <= 32'(num[c][45:16]);
                            nlo_reg[c] <= num[c][15:0];
                            q_reg[c]   <= '0;
                        end
                        else
                        begin
                            rem_reg[c] <= ge[c] ? 32'(rem2[c] - {1'b0, len_reg})
                                                : rem2[c][31:0];
                            nlo_reg[c] <= nlo_reg[c] << 1;
                            q_reg[c]   <= {q_reg[c][14:0], ge[c]};
                        end
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                    begin
                        res_deg_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        tan_valid_reg <= 1'b1;
                        deg_out_reg   <= res_deg_reg;
                        last_reg      <= (vtx_reg == 2'd2);
                        for (int c = 0; c < 3; c++)
                        begin
                            if (res_deg_reg)
                                tan_reg[c] <= '0;
                            else
                                tan_reg[c] <= w_reg[c][56] ? -$signed(q_reg[c])
                                                           : $signed(q_reg[c]);
                        end
                        if (vtx_reg == 2'd2)
                            state_reg <= S_IDLE;
                        else
                        begin
                            vtx_reg <= vtx_reg + 2'd1;
                            k_reg   <= '0;
                            state_reg <= degtri_reg ? S_OUT : S_DOT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/triangle_tangent_frame.sv @@
// Top level of the per-triangle tangent block: front, queue and back.
// Depends on ttf_pkg, ttf_front, ttf_queue and ttf_back.
//
//   channel   handshake            payload
//   vertex    vtx_valid/vtx_ready  pos_x..z, tex_u, tex_v, norm_x..z
//   tangent   tan_valid/tan_ready  tan_x..z, degenerate, last_of_triangle
//
// The first two vertices of a group are taken in one cycle each.
// A triangle runs 8 shared-multiplier steps and one-bit shifts of the direction, then per
// vertex a 32-step square root and a 16-step divide; a degenerate triangle skips the
// per-vertex steps and gives zero tangents.
// The queue holds QUEUE_DEPTH finished triangles so the intake keeps going while the back works.
// A stalled tangent sits in the output register; the back runs on up to its next result.
// Reset clears slot count, queue and sequencer; no clearing pass.
module triangle_tangent_frame import ttf_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    vtx_valid,
    output logic                    vtx_ready,
    input  logic signed [PosW-1:0]  pos_x,
    input  logic signed [PosW-1:0]  pos_y,
    input  logic signed [PosW-1:0]  pos_z,
    input  logic signed [PosW-1:0]  tex_u,
    input  logic signed [PosW-1:0]  tex_v,
    input  logic signed [NormW-1:0] norm_x,
    input  logic signed [NormW-1:0] norm_y,
    input  logic signed [NormW-1:0] norm_z,
    output logic                    tan_valid,
    input  logic                    tan_ready,
    output logic signed [TanW-1:0]  tan_x,
    output logic signed [TanW-1:0]  tan_y,
    output logic signed [TanW-1:0]  tan_z,
    output logic                    degenerate,
    output logic                    last_of_triangle
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    tri_t q_in;
    tri_t q_out;

    ttf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    ttf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ttf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_data           (q_out),
        .tan_valid        (tan_valid),
        .tan_ready        (tan_ready),
        .tan_x            (tan_x),
        .tan_y            (tan_y),
        .tan_z            (tan_z),
        .degenerate       (degenerate),
        .last_of_triangle (last_of_triangle)
    );

endmodule

@@ rtl/ttf_checker.sv @@
// Port-level checks for triangle_tangent_frame, attached by bind.
// Depends on ttf_pkg.
module ttf_checker import ttf_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    vtx_valid,
    input logic                    vtx_ready,
    input logic                    tan_valid,
    input logic                    tan_ready,
    input logic signed [TanW-1:0]  tan_x,
    input logic signed [TanW-1:0]  tan_y,
    input logic signed [TanW-1:0]  tan_z,
    input logic                    degenerate,
    input logic                    last_of_triangle
);

    logic [1:0] in_slot_reg;
    logic [7:0] tri_in_reg;
    logic [7:0] tri_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_slot_reg <= '0;
            tri_in_reg  <= '0;
            tri_out_reg <= '0;
        end
        else
        begin
            if (vtx_valid && vtx_ready)
            begin
                in_slot_reg <= (in_slot_reg == 2'd2) ? 2'd0 : in_slot_reg + 2'd1;
                if (in_slot_reg == 2'd2)
                    tri_in_reg <= tri_in_reg + 8'd1;
            end
            if (tan_valid && tan_ready && last_of_triangle)
                tri_out_reg <= tri_out_reg + 8'd1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid && !tan_ready |=> tan_valid && $stable(tan_x) && $stable(tan_y)
            && $stable(tan_z) && $stable(degenerate) && $stable(last_of_triangle))
        else $error("tangent changed while stalled");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid && degenerate |-> tan_x == '0 && tan_y == '0 && tan_z == '0)
        else $error("degenerate result with nonzero tangent");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid |-> tan_x >= -16'sd16384 && tan_x <= 16'sd16384
            && tan_y >= -16'sd16384 && tan_y <= 16'sd16384
            && tan_z >= -16'sd16384 && tan_z <= 16'sd16384)
        else $error("tangent component out of unit range");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid && tan_ready && last_of_triangle |-> tri_in_reg != tri_out_reg)
        else $error("triangle result without a triangle taken in");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);

@@ tb/tb_triangle_tangent_frame.sv @@
// Self-checking bench for triangle_tangent_frame: vertex groups in, tangents out.
// Depends on ttf_pkg and the RTL top; it predicts every result from its own fixed-point model.
module tb_triangle_tangent_frame;
    import ttf_pkg::*;

    localparam int HalfPeriod = 6;
    localparam int ResetCycles = 9;
    localparam int QuietLimit = 3000;
    localparam int TailCycles = 400;
    localparam int CalmItems = 60;
    localparam int ShownErrors = 10;

    typedef struct {
        logic signed [PosW-1:0]  px, py, pz, tu, tv;
        logic signed [NormW-1:0] nx, ny, nz;
        bit                      drain;
    } vertex_t;

    typedef struct {
        logic signed [TanW-1:0] x, y, z;
        logic                   degen;
        logic                   last;
    } tangent_t;

    logic clk;
    logic rst_n;
    logic vtx_valid, vtx_ready;
    logic signed [PosW-1:0]  pos_x, pos_y, pos_z, tex_u, tex_v;
    logic signed [NormW-1:0] norm_x, norm_y, norm_z;
    logic tan_valid, tan_ready;
    logic signed [TanW-1:0] tan_x, tan_y, tan_z;
    logic degenerate, last_of_triangle;

    triangle_tangent_frame dut (
        .clk(clk), .rst_n(rst_n),
        .vtx_valid(vtx_valid), .vtx_ready(vtx_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tan_valid(tan_valid), .tan_ready(tan_ready),
        .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
        .degenerate(degenerate), .last_of_triangle(last_of_triangle)
    );

    vertex_t  vertex_queue[$];
    tangent_t tangent_queue[$];
    int       errors = 0;
    int       vertices_in = 0;
    int       tangents_out = 0;
    int       degen_seen = 0;
    int       triangles = 0;

    // predictor state
    int     group_slot = 0;
    longint held_pos[2][3];
    longint held_uv[2][2];
    longint held_nrm[2][3];

    initial
    begin
        clk = 1'b0;
        forever #HalfPeriod clk = ~clk;
    end

    // Shift the first n values by one common floor shift into [-2^lim_log, 2^lim_log).
    function automatic void align(inout longint v[6], input int n, input int lim_log);
        longint unsigned m;
        longint unsigned a;
        int sh;
        m = 0;
        sh = 0;
        for (int i = 0; i < n; i++)
        begin
            a = (v[i] >= 0) ? v[i] : ~v[i];
            if (a > m)
                m = a;
        end
        while ((m >> sh) >= (64'd1 << lim_log))
            sh++;
        for (int i = 0; i < n; i++)
            v[i] = v[i] >>> sh;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Project out the normal, normalize to Q2.14; returns 0 when nothing is left.
    function automatic bit orthonormal(input longint d[6], input longint n[3],
                                       output longint t[3]);
        longint u[6];
        longint w[6];
        longint dot;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned q;
        u = d;
        t = '{0, 0, 0};
        align(u, 3, 23);
        dot = n[0] * u[0] + n[1] * u[1] + n[2] * u[2];
        w = '{0, 0, 0, 0, 0, 0};
        for (int c = 0; c < 3; c++)
            w[c] = u[c] * (64'sd1 <<< 28) - n[c] * dot;
        if (w[0] == 0 && w[1] == 0 && w[2] == 0)
            return 1'b0;
        align(w, 3, 31);
        sum = 0;
        for (int c = 0; c < 3; c++)
            sum += longint'(w[c] * w[c]);
        len = floor_sqrt(sum);
        for (int c = 0; c < 3; c++)
        begin
            mag = (w[c] >= 0) ? w[c] : -w[c];
            q = ((mag << 14) + (len >> 1)) / len;
            t[c] = (w[c] >= 0) ? longint'(q) : -longint'(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_vertex(input vertex_t v);
        longint cur_pos[3];
        longint cur_uv[2];
        longint nrm[3][3];
        longint e[6];
        longint s[6];
        longint d[6];
        longint det;
        longint t[3];
        longint nk[3];
        bit ok;
        tangent_t r;
        cur_pos = '{longint'(v.px), longint'(v.py), longint'(v.pz)};
        cur_uv = '{longint'(v.tu), longint'(v.tv)};
        if (group_slot < 2)
        begin
            held_pos[group_slot] = cur_pos;
            held_uv[group_slot] = cur_uv;
            held_nrm[group_slot] = '{longint'(v.nx), longint'(v.ny), longint'(v.nz)};
            group_slot++;
            return;
        end
        group_slot = 0;
        triangles++;
        nrm[0] = held_nrm[0];
        nrm[1] = held_nrm[1];
        nrm[2] = '{longint'(v.nx), longint'(v.ny), longint'(v.nz)};
        for (int c = 0; c < 3; c++)
        begin
            e[c] = held_pos[1][c] - held_pos[0][c];
            e[3 + c] = cur_pos[c] - held_pos[0][c];
        end
        align(e, 6, 30);
        s = '{held_uv[1][0] - held_uv[0][0], held_uv[1][1] - held_uv[0][1],
              cur_uv[0] - held_uv[0][0], cur_uv[1] - held_uv[0][1], 0, 0};
        align(s, 4, 30);
        det = s[0] * s[3] - s[2] * s[1];
        d = '{0, 0, 0, 0, 0, 0};
        for (int c = 0; c < 3; c++)
        begin
            d[c] = s[3] * e[c] - s[1] * e[3 + c];
            if (det < 0)
                d[c] = -d[c];
        end
        for (int k = 0; k < 3; k++)
        begin
            ok = 1'b0;
            t = '{0, 0, 0};
            nk = nrm[k];
            if (det != 0)
                ok = orthonormal(d, nk, t);
            if (!ok)
                t = '{0, 0, 0};
            r.x = t[0][TanW-1:0];
            r.y = t[1][TanW-1:0];
            r.z = t[2][TanW-1:0];
            r.degen = !ok;
            r.last = (k == 2);
            tangent_queue.push_back(r);
        end
    endtask

    function automatic vertex_t mk(input longint px, py, pz, tu, tv,
                                   input int nx, ny, nz);
        vertex_t v;
        v.px = px[PosW-1:0];
        v.py = py[PosW-1:0];
        v.pz = pz[PosW-1:0];
        v.tu = tu[PosW-1:0];
        v.tv = tv[PosW-1:0];
        v.nx = nx[NormW-1:0];
        v.ny = ny[NormW-1:0];
        v.nz = nz[NormW-1:0];
        v.drain = 1'b0;
        return v;
    endfunction

    function automatic int rand_norm();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16384 : -16384;
            1: return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // Mesh-like triangle: random base, bounded deltas; occasionally fully random fields.
    task automatic add_random_triangle(input bit drain);
        longint base[5];
        longint span;
        vertex_t v;
        bit wild;
        wild = ($urandom_range(0, 9) < 3);
        span = longint'(1) << $urandom_range(0, 30);
        for (int i = 0; i < 5; i++)
            base[i] = longint'($signed($urandom));
        for (int k = 0; k < 3; k++)
        begin
            if (wild)
                v = mk($signed($urandom), $signed($urandom), $signed($urandom),
                       $signed($urandom), $signed($urandom),
                       rand_norm(), rand_norm(), rand_norm());
            else
                v = mk(base[0] + $urandom_range(0, 32'(span)),
                       base[1] + $urandom_range(0, 32'(span)),
                       base[2] + $urandom_range(0, 32'(span)),
                       base[3] + $urandom_range(0, 32'(span)),
                       base[4] + $urandom_range(0, 32'(span)),
                       rand_norm(), rand_norm(), rand_norm());
            v.drain = drain && (k == 0);
            vertex_queue.push_back(v);
        end
    endtask

    // vertex driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid <= 1'b0;
            pos_x <= '0; pos_y <= '0; pos_z <= '0;
            tex_u <= '0; tex_v <= '0;
            norm_x <= '0; norm_y <= '0; norm_z <= '0;
        end
        else if (!vtx_valid || vtx_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                vtx_valid <= 1'b0;
            end
            else if (vertex_queue.size() > 0 &&
                     !(vertex_queue[0].drain && (vtx_valid || tangent_queue.size() > 0)))
            begin
                pos_x <= vertex_queue[0].px; pos_y <= vertex_queue[0].py;
                pos_z <= vertex_queue[0].pz;
                tex_u <= vertex_queue[0].tu; tex_v <= vertex_queue[0].tv;
                norm_x <= vertex_queue[0].nx; norm_y <= vertex_queue[0].ny;
                norm_z <= vertex_queue[0].nz;
                vtx_valid <= 1'b1;
                void'(vertex_queue.pop_front());
                if (vertex_queue.size() > CalmItems && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 6);
            end
            else
                vtx_valid <= 1'b0;
        end
    end

    // tangent sink with stall bursts
    int sink_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tan_ready <= 1'b0;
        else if (sink_stall > 0)
        begin
            tan_ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            tan_ready <= 1'b1;
            if (vertex_queue.size() > CalmItems && $urandom_range(0, 4) == 0)
                sink_stall <= $urandom_range(1, 6);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        tangent_t want;
        vertex_t got;
        if (rst_n && tan_valid && tan_ready)
        begin
            tangents_out++;
            if (degenerate)
                degen_seen++;
            if (tangent_queue.size() == 0)
            begin
                errors++;
                if (errors <= ShownErrors)
                    $display("ERROR: unexpected tangent %0d %0d %0d degen=%0b last=%0b",
                             tan_x, tan_y, tan_z, degenerate, last_of_triangle);
            end
            else
            begin
                want = tangent_queue.pop_front();
                if (tan_x !== want.x || tan_y !== want.y || tan_z !== want.z ||
                    degenerate !== want.degen || last_of_triangle !== want.last)
                begin
                    errors++;
                    if (errors <= ShownErrors)
                        $display("ERROR: tangent %0d: want %0d %0d %0d d=%0b l=%0b, got %0d %0d %0d d=%0b l=%0b",
                                 tangents_out, want.x, want.y, want.z, want.degen, want.last,
                                 tan_x, tan_y, tan_z, degenerate, last_of_triangle);
                end
            end
        end
        if (rst_n && vtx_valid && vtx_ready)
        begin
            vertices_in++;
            got.px = pos_x; got.py = pos_y; got.pz = pos_z;
            got.tu = tex_u; got.tv = tex_v;
            got.nx = norm_x; got.ny = norm_y; got.nz = norm_z;
            got.drain = 1'b0;
            predict_vertex(got);
        end
    end

    // watchdog: quiet cycles with no transfer on either channel
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((vtx_valid && vtx_ready) || (tan_valid && tan_ready))
            quiet <= 0;
        else if (rst_n && (vertex_queue.size() > 0 || tangent_queue.size() > 0 || vtx_valid))
        begin
            quiet <= quiet + 1;
            if (quiet >= QuietLimit)
            begin
                $display("timeout: %0d tangents still awaited", tangent_queue.size());
                $display("triangle_tangent_frame verification failed");
                $finish;
            end
        end
    end

    localparam longint PMax = 64'sd2147483647;
    localparam longint PMin = -64'sd2147483648;
    localparam longint One = 64'sd65536;

    initial
    begin
        rst_n = 1'b0;
        // unit right triangle, +z normals
        vertex_queue.push_back(mk(0, 0, 0, 0, 0, 0, 0, 16384));
        vertex_queue.push_back(mk(One, 0, 0, One, 0, 0, 0, 16384));
        vertex_queue.push_back(mk(0, One, 0, 0, One, 0, 0, 16384));
        // zero UV determinant
        vertex_queue.push_back(mk(0, 0, 0, 5, 7, 0, 0, 16384));
        vertex_queue.push_back(mk(One, 0, 0, 5, 7, 0, 0, 16384));
        vertex_queue.push_back(mk(0, One, 0, 5, 7, 0, 0, 16384));
        // first normal parallel to the tangent: nothing left after projection
        vertex_queue.push_back(mk(0, 0, 0, 0, 0, 16384, 0, 0));
        vertex_queue.push_back(mk(One, 0, 0, One, 0, -16384, 0, 0));
        vertex_queue.push_back(mk(0, One, 0, 0, One, 0, 16384, 0));
        // full-scale positions and UVs, extreme normals
        vertex_queue.push_back(mk(PMin, PMin, PMin, PMin, PMin, -32768, -32768, -32768));
        vertex_queue.push_back(mk(PMax, PMax, PMax, PMax, PMin, 32767, 32767, 32767));
        vertex_queue.push_back(mk(PMax, PMin, 0, PMin, PMax, -32768, 32767, 0));
        // negative determinant (mirrored UVs)
        vertex_queue.push_back(mk(0, 0, 0, 0, 0, 0, 16384, 0));
        vertex_queue.push_back(mk(One, 0, 0, 0, One, 0, 16384, 0));
        vertex_queue.push_back(mk(0, 0, One, One, 0, 0, 16384, 0));
        // zero and non-unit normals
        vertex_queue.push_back(mk(3, 1, 4, 1, 5, 0, 0, 0));
        vertex_queue.push_back(mk(9, 2, 6, 5, 3, 100, -7, 3));
        vertex_queue.push_back(mk(-5, 8, 9, 7, -9, 32767, 0, -1));
        // collinear positions: the direction runs along their line
        vertex_queue.push_back(mk(10, 10, 10, 0, 0, 0, 0, 16384));
        vertex_queue.push_back(mk(20, 20, 20, One, 0, 0, 0, 16384));
        vertex_queue.push_back(mk(30, 30, 30, 0, One, 0, 0, 16384));
        // LSB-sized edges
        vertex_queue.push_back(mk(-1, -1, -1, -1, -1, 1, 1, 1));
        vertex_queue.push_back(mk(0, -1, -1, 0, -1, -1, 2, 1));
        vertex_queue.push_back(mk(-1, 0, -1, -1, 0, 1, 1, -2));
        for (int i = 0; i < 149; i++)
            add_random_triangle(i == 40 || i == 100);

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        wait (vertex_queue.size() == 0 && !vtx_valid);
        wait (tangent_queue.size() == 0);
        repeat (TailCycles) @(posedge clk);

        $display("%0d vertices in %0d triangles sent, %0d tangents checked (%0d degenerate)",
                 vertices_in, triangles, tangents_out, degen_seen);
        $display("errors: %0d", errors);
        if (errors == 0 && tangent_queue.size() == 0)
            $display("triangle_tangent_frame verification clean");
        else
            $display("triangle_tangent_frame verification failed");
        $finish;
    end

endmodule
